FILE: rtl/sttab_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sttab_pkg
// Shared types and constants of the software timer slot table.
// ---------------------------------------------------------------------------
package sttab_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int DELAY_BITS = 32;
   localparam int WORD_BITS  = 2 * DELAY_BITS;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SETUP   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_SERVICE = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_ONCE   = 2'd0;
   localparam logic [1:0] KIND_CYCLIC = 2'd1;

   // per-slot word held in the slot memory
   typedef struct packed {
      logic [DELAY_BITS-1:0] reload;
      logic [DELAY_BITS-1:0] remain;
   } slot_word_type;

endpackage

FILE: rtl/sttab_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sttab_ram
// Generic single write port, single read port memory with registered read.
// ---------------------------------------------------------------------------
module sttab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/software_timer_slot_table.sv
`timescale 1ns / 1ps
// Create writes the slot directly, or first compacts the order memory when
// the slot is already armed; release compacts the order memory; tick does one
// slot memory read-modify-write per cycle; service walks the order memory, plus
// removal of a non-cyclic slot. One transaction at a time; busy covers the walk.
// Reset clears all flags and the order count; memories need no clearing.
// The receiver cannot stall: each result shows for one cycle on rsp_strobe.
// ---------------------------------------------------------------------------
// software_timer_slot_table
// Timer slot table with an order memory and a slot data memory, driven by
// a sequencer that walks them for tick, create, release and service.
// ---------------------------------------------------------------------------
module software_timer_slot_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_timer_kind,
   input  logic [31:0] req_start_delay,
   input  logic [31:0] req_reload_ticks,
   input  logic        req_has_handler,
   output logic        rsp_strobe,
   output logic        rsp_fired,
   output logic [3:0]  rsp_fired_slot,
   output logic        rsp_release_ok,
   output logic        rsp_slot_expired,
   output logic        rsp_slot_armed
);

   localparam int SB = sttab_pkg::SLOT_BITS;
   localparam int CB = sttab_pkg::CNT_BITS;
   localparam int DB = sttab_pkg::DELAY_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TICK, ST_DROP, ST_CREATE, ST_SVC, ST_SVC_ACT, ST_DONE
   } st_type;

   st_type                     state_ff, state_in;
   sttab_pkg::cmd_type         cmd_ff, cmd_in;
   logic [SB-1:0]              slot_ff, slot_in;
   logic [1:0]                 req_kind_ff, req_kind_in;
   logic [DB-1:0]              delay_ff, delay_in;
   logic [DB-1:0]              reload_ff, reload_in;
   logic                       req_hnd_ff, req_hnd_in;
   logic [SB-1:0]              tgt_ff, tgt_in;
   logic [CB-1:0]              rd_ff, rd_in;
   logic [CB-1:0]              wr_ff, wr_in;
   logic                       pend_ff, pend_in;
   logic [SB-1:0]              pslot_ff, pslot_in;
   logic [CB-1:0]              count_ff, count_in;
   logic [sttab_pkg::SLOTS-1:0] armed_ff, armed_in;
   logic [sttab_pkg::SLOTS-1:0] expired_ff, expired_in;
   logic [sttab_pkg::SLOTS-1:0] defer_ff, defer_in;
   logic [sttab_pkg::SLOTS-1:0] hnd_ff, hnd_in;
   logic                       fired_ff, fired_in;
   logic [SB-1:0]              fired_slot_ff, fired_slot_in;
   logic                       ok_ff, ok_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic                       rsp_fired_ff, rsp_fired_in;
   logic [SB-1:0]              rsp_fired_slot_ff, rsp_fired_slot_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic                       rsp_exp_ff, rsp_exp_in;
   logic                       rsp_arm_ff, rsp_arm_in;
   logic [1:0]                 kind_tab_ff [sttab_pkg::SLOTS];
   logic                       kt_we;

   logic                       ord_we;
   logic [SB-1:0]              ord_waddr, ord_raddr, ord_wdata, ord_rdata;
   logic                       dat_we;
   logic [SB-1:0]              dat_waddr, dat_raddr;
   sttab_pkg::slot_word_type   dat_wdata, dat_rdata;

   // order memory: slot indexes in creation order
   sttab_ram #(.WIDTH(SB), .DEPTH(sttab_pkg::SLOTS)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   // slot memory: reload value and remaining ticks
   sttab_ram #(.WIDTH(sttab_pkg::WORD_BITS), .DEPTH(sttab_pkg::SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (dat_we),
      .wr_addr (dat_waddr),
      .wr_data (dat_wdata),
      .rd_addr (dat_raddr),
      .rd_data (dat_rdata)
   );

   // sequencer next state
   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      slot_in           = slot_ff;
      req_kind_in       = req_kind_ff;
      delay_in          = delay_ff;
      reload_in         = reload_ff;
      req_hnd_in        = req_hnd_ff;
      tgt_in            = tgt_ff;
      rd_in             = rd_ff;
      wr_in             = wr_ff;
      pend_in           = pend_ff;
      pslot_in          = pslot_ff;
      count_in          = count_ff;
      armed_in          = armed_ff;
      expired_in        = expired_ff;
      defer_in          = defer_ff;
      hnd_in            = hnd_ff;
      fired_in          = fired_ff;
      fired_slot_in     = fired_slot_ff;
      ok_in             = ok_ff;
      rsp_strobe_in     = 1'b0;
      rsp_fired_in      = rsp_fired_ff;
      rsp_fired_slot_in = rsp_fired_slot_ff;
      rsp_ok_in         = rsp_ok_ff;
      rsp_exp_in        = rsp_exp_ff;
      rsp_arm_in        = rsp_arm_ff;
      kt_we             = 1'b0;
      ord_we            = 1'b0;
      ord_waddr         = wr_ff[SB-1:0];
      ord_wdata         = ord_rdata;
      ord_raddr         = rd_ff[SB-1:0];
      dat_we            = 1'b0;
      dat_waddr         = pslot_ff;
      dat_wdata         = dat_rdata;
      dat_raddr         = rd_ff[SB-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in        = sttab_pkg::cmd_type'(req_cmd);
               slot_in       = req_slot;
               req_kind_in   = req_timer_kind;
               delay_in      = req_start_delay[DB-1:0];
               reload_in     = req_reload_ticks[DB-1:0];
               req_hnd_in    = req_has_handler;
               tgt_in        = req_slot;
               rd_in         = '0;
               wr_in         = '0;
               pend_in       = 1'b0;
               fired_in      = 1'b0;
               fired_slot_in = '0;
               ok_in         = 1'b0;
               case (sttab_pkg::cmd_type'(req_cmd))
                  sttab_pkg::CMD_TICK:    state_in = ST_TICK;
                  sttab_pkg::CMD_SETUP:   state_in = armed_ff[req_slot] ? ST_DROP : ST_CREATE;
                  sttab_pkg::CMD_RELEASE: begin
                     ok_in    = armed_ff[req_slot];
                     state_in = armed_ff[req_slot] ? ST_DROP : ST_DONE;
                  end
                  default:                state_in = ST_SVC;
               endcase
            end
         end

         // count down every armed slot, one memory entry per cycle
         ST_TICK: begin
            pend_in = 1'b0;
            if (rd_ff < CB'(sttab_pkg::SLOTS)) begin
               dat_raddr = rd_ff[SB-1:0];
               pslot_in  = rd_ff[SB-1:0];
               rd_in     = rd_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff && armed_ff[pslot_ff] && dat_rdata.remain != '0) begin
               dat_we           = 1'b1;
               dat_waddr        = pslot_ff;
               dat_wdata.reload = dat_rdata.reload;
               dat_wdata.remain = dat_rdata.remain - 1'b1;
               if (dat_rdata.remain == DB'(1)) begin
                  expired_in[pslot_ff] = 1'b1;
               end
            end
            if (rd_ff == CB'(sttab_pkg::SLOTS) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         // compact the order list without the target slot
         ST_DROP: begin
            pend_in = 1'b0;
            if (rd_ff < count_ff) begin
               rd_in   = rd_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && ord_rdata != tgt_ff) begin
               ord_we    = 1'b1;
               ord_waddr = wr_ff[SB-1:0];
               ord_wdata = ord_rdata;
               wr_in     = wr_ff + 1'b1;
            end
            if (rd_ff == count_ff && !pend_ff) begin
               count_in        = wr_ff;
               armed_in[tgt_ff] = 1'b0;
               state_in        = (cmd_ff == sttab_pkg::CMD_SETUP) ? ST_CREATE : ST_DONE;
            end
         end

         // arm the slot and append it at the tail
         ST_CREATE: begin
            dat_we            = 1'b1;
            dat_waddr         = slot_ff;
            dat_wdata.reload  = reload_ff;
            dat_wdata.remain  = (delay_ff == '0) ? DB'(1) : delay_ff;
            ord_we            = 1'b1;
            ord_waddr         = count_ff[SB-1:0];
            ord_wdata         = slot_ff;
            count_in          = count_ff + 1'b1;
            kt_we             = 1'b1;
            hnd_in[slot_ff]     = req_hnd_ff;
            expired_in[slot_ff] = 1'b0;
            defer_in[slot_ff]   = 1'b0;
            armed_in[slot_ff]   = 1'b1;
            state_in          = ST_DONE;
         end

         // walk the order list for the first expired slot without deferral, clearing deferral on expired slots passed
         ST_SVC: begin
            pend_in = 1'b0;
            if (rd_ff < count_ff) begin
               rd_in   = rd_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && expired_ff[ord_rdata]) begin
               if (defer_ff[ord_rdata]) begin
                  defer_in[ord_rdata] = 1'b0;
               end else begin
                  tgt_in    = ord_rdata;
                  dat_raddr = ord_rdata;
                  pend_in   = 1'b0;
                  state_in  = ST_SVC_ACT;
               end
            end else if (rd_ff == count_ff && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         // process the found slot by its kind
         ST_SVC_ACT: begin
            rd_in   = '0;
            wr_in   = '0;
            pend_in = 1'b0;
            if (kind_tab_ff[tgt_ff] == sttab_pkg::KIND_CYCLIC) begin
               dat_we              = 1'b1;
               dat_waddr           = tgt_ff;
               dat_wdata.reload    = dat_rdata.reload;
               dat_wdata.remain    = dat_rdata.reload;
               defer_in[tgt_ff]    = 1'b1;
               expired_in[tgt_ff]  = 1'b0;
               fired_in            = hnd_ff[tgt_ff];
               fired_slot_in       = hnd_ff[tgt_ff] ? tgt_ff : '0;
               state_in            = ST_DONE;
            end else begin
               if (kind_tab_ff[tgt_ff] == sttab_pkg::KIND_ONCE) begin
                  fired_in      = hnd_ff[tgt_ff];
                  fired_slot_in = hnd_ff[tgt_ff] ? tgt_ff : '0;
               end
               state_in = ST_DROP;
            end
         end

         // present the result for one cycle
         ST_DONE: begin
            rsp_strobe_in     = 1'b1;
            rsp_fired_in      = fired_ff;
            rsp_fired_slot_in = fired_slot_ff;
            rsp_ok_in         = ok_ff;
            rsp_exp_in        = expired_ff[slot_ff];
            rsp_arm_in        = armed_ff[slot_ff];
            state_in          = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ff         <= '0;
         wr_ff         <= '0;
         pend_ff       <= 1'b0;
         count_ff      <= '0;
         armed_ff      <= '0;
         expired_ff    <= '0;
         defer_ff      <= '0;
         hnd_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
         armed_ff      <= armed_in;
         expired_ff    <= expired_in;
         defer_ff      <= defer_in;
         hnd_ff        <= hnd_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff            <= cmd_in;
      slot_ff           <= slot_in;
      req_kind_ff       <= req_kind_in;
      delay_ff          <= delay_in;
      reload_ff         <= reload_in;
      req_hnd_ff        <= req_hnd_in;
      tgt_ff            <= tgt_in;
      pslot_ff          <= pslot_in;
      fired_ff          <= fired_in;
      fired_slot_ff     <= fired_slot_in;
      ok_ff             <= ok_in;
      rsp_fired_ff      <= rsp_fired_in;
      rsp_fired_slot_ff <= rsp_fired_slot_in;
      rsp_ok_ff         <= rsp_ok_in;
      rsp_exp_ff        <= rsp_exp_in;
      rsp_arm_ff        <= rsp_arm_in;
      if (kt_we) begin
         kind_tab_ff[slot_ff] <= req_kind_ff;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_slot   = rsp_fired_slot_ff;
   assign rsp_release_ok   = rsp_ok_ff;
   assign rsp_slot_expired = rsp_exp_ff;
   assign rsp_slot_armed   = rsp_arm_ff;

   // order list length never exceeds the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(sttab_pkg::SLOTS))
      else $error("order count out of range");

   // between transactions the order list length equals the number of armed slots
   a_count_armed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(armed_ff) == 32'(count_ff)))
      else $error("order count differs from armed slots");

   // a successful release leaves the addressed slot disarmed
   a_release_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ok_ff) |-> !rsp_arm_ff)
      else $error("released slot still armed");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted without going busy");

endmodule

FILE: bench/tb_software_timer_slot_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_software_timer_slot_table
// Self-checking bench for the timer slot table. A directed table covers
// reset state, delay extremes, every command and timer kind, the defer bit
// and re-creation of an armed slot. Random command streams with small delays
// follow. Untyped rows are checked against an in-bench model of the table.
// ---------------------------------------------------------------------------
module tb_software_timer_slot_table;

   localparam logic [1:0] KIND_DELAY = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_ITEMS  = 200;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic       fired;
      logic [3:0] fired_slot;
      logic       release_ok;
      logic       slot_expired;
      logic       slot_armed;
   } status_type;

   typedef struct {
      sttab_pkg::cmd_type cmd;
      logic [3:0]  slot;
      logic [1:0]  kind;
      logic [31:0] delay;
      logic [31:0] reload;
      logic        handler;
      bit          typed;
      status_type  want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [3:0]  req_slot;
   logic [1:0]  req_timer_kind;
   logic [31:0] req_start_delay;
   logic [31:0] req_reload_ticks;
   logic        req_has_handler;
   logic        rsp_strobe;
   logic        rsp_fired;
   logic [3:0]  rsp_fired_slot;
   logic        rsp_release_ok;
   logic        rsp_slot_expired;
   logic        rsp_slot_armed;

   // model state of the slot table
   bit          armed_q   [sttab_pkg::SLOTS];
   bit          expired_q [sttab_pkg::SLOTS];
   bit          defer_q   [sttab_pkg::SLOTS];
   bit          handler_q [sttab_pkg::SLOTS];
   logic [1:0]  kind_q    [sttab_pkg::SLOTS];
   logic [31:0] remain_q  [sttab_pkg::SLOTS];
   logic [31:0] reload_q  [sttab_pkg::SLOTS];
   logic [3:0]  order_q   [$];

   status_type  pending_status [$];
   int          errors;
   int          idle_cycles;
   bit          quiet;

   software_timer_slot_table dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report(input string what, input int want, input int got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      errors++;
   endtask

   function automatic void drop_slot(input logic [3:0] s);
      for (int i = order_q.size() - 1; i >= 0; i--)
         if (order_q[i] == s) order_q.delete(i);
      armed_q[s] = 0;
   endfunction

   // next status of the table for one command
   function automatic status_type table_step(input sttab_pkg::cmd_type cmd,
                                             input logic [3:0] s,
                                             input logic [1:0] kind,
                                             input logic [31:0] delay,
                                             input logic [31:0] reload,
                                             input logic handler);
      status_type r;
      logic [3:0] t;
      r = '0;
      case (cmd)
         sttab_pkg::CMD_TICK: begin
            foreach (order_q[i]) begin
               t = order_q[i];
               if (remain_q[t] != 0) begin
                  remain_q[t]--;
                  if (remain_q[t] == 0) expired_q[t] = 1;
               end
            end
         end
         sttab_pkg::CMD_SETUP: begin
            if (armed_q[s]) drop_slot(s);
            kind_q[s]    = kind;
            expired_q[s] = 0;
            defer_q[s]   = 0;
            remain_q[s]  = (delay == 0) ? 32'd1 : delay;
            reload_q[s]  = reload;
            handler_q[s] = handler;
            order_q.push_back(s);
            armed_q[s]   = 1;
         end
         sttab_pkg::CMD_RELEASE: begin
            if (armed_q[s]) begin
               drop_slot(s);
               r.release_ok = 1;
            end
         end
         default: begin
            // walk in creation order, first expired slot without defer wins
            for (int i = 0; i < order_q.size(); i++) begin
               t = order_q[i];
               if (!expired_q[t]) continue;
               if (defer_q[t]) begin
                  defer_q[t] = 0;
                  continue;
               end
               if (kind_q[t] == sttab_pkg::KIND_CYCLIC) begin
                  defer_q[t]   = 1;
                  expired_q[t] = 0;
                  remain_q[t]  = reload_q[t];
               end else begin
                  drop_slot(t);
               end
               if (kind_q[t] != KIND_DELAY && kind_q[t] != KIND_SPARE && handler_q[t]) begin
                  r.fired      = 1;
                  r.fired_slot = t;
               end
               break;
            end
         end
      endcase
      r.slot_expired = expired_q[s];
      r.slot_armed   = armed_q[s];
      return r;
   endfunction

   // present one transaction and wait until the table is no longer busy
   task automatic send(input row_type row);
      status_type got;
      @(negedge clock);
      start            = 1'b1;
      req_cmd          = row.cmd;
      req_slot         = row.slot;
      req_timer_kind   = row.kind;
      req_start_delay  = row.delay;
      req_reload_ticks = row.reload;
      req_has_handler  = row.handler;
      do @(posedge clock); while (busy);
      got = table_step(row.cmd, row.slot, row.kind, row.delay, row.reload, row.handler);
      pending_status.push_back(row.typed ? row.want : got);
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      start            = 1'b0;
      req_cmd          = 2'($urandom);
      req_start_delay  = $urandom;
      req_reload_ticks = $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   // result check
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_strobe) begin
         if (pending_status.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            errors++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_fired !== want.fired) report("fired", want.fired, rsp_fired);
            if (rsp_fired_slot !== want.fired_slot)
               report("fired_slot", want.fired_slot, rsp_fired_slot);
            if (rsp_release_ok !== want.release_ok)
               report("release_ok", want.release_ok, rsp_release_ok);
            if (rsp_slot_expired !== want.slot_expired)
               report("slot_expired", want.slot_expired, rsp_slot_expired);
            if (rsp_slot_armed !== want.slot_armed)
               report("slot_armed", want.slot_armed, rsp_slot_armed);
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic row_type make_row(input sttab_pkg::cmd_type c, input logic [3:0] s,
                                        input logic [1:0] k, input logic [31:0] d,
                                        input logic [31:0] rl, input logic h,
                                        input bit typed, input status_type w);
      row_type row;
      row.cmd = c; row.slot = s; row.kind = k; row.delay = d;
      row.reload = rl; row.handler = h; row.typed = typed; row.want = w;
      return row;
   endfunction

   function automatic row_type random_row();
      int pick;
      logic [31:0] d, rl;
      sttab_pkg::cmd_type c;
      pick = $urandom_range(0, 99);
      if (pick < 40) c = sttab_pkg::CMD_TICK;
      else if (pick < 65) c = sttab_pkg::CMD_SETUP;
      else if (pick < 77) c = sttab_pkg::CMD_RELEASE;
      else c = sttab_pkg::CMD_SERVICE;
      // small delays so slots actually expire; wide values now and then
      d  = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5);
      rl = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4);
      return make_row(c, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5)),
                      2'($urandom), d, rl, 1'($urandom), 0, '0);
   endfunction

   row_type directed [$];

   initial begin
      errors           = 0;
      idle_cycles      = 0;
      quiet            = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = sttab_pkg::CMD_TICK;
      req_slot         = '0;
      req_timer_kind   = sttab_pkg::KIND_ONCE;
      req_start_delay  = '0;
      req_reload_ticks = '0;
      req_has_handler  = 1'b0;
      foreach (armed_q[i]) begin
         armed_q[i] = 0; expired_q[i] = 0; defer_q[i] = 0; handler_q[i] = 0;
         kind_q[i] = sttab_pkg::KIND_ONCE; remain_q[i] = '0; reload_q[i] = '0;
      end

      // stimulus table: typed rows carry an obvious expected status
      directed = '{
         make_row(sttab_pkg::CMD_RELEASE, 4'd5, sttab_pkg::KIND_ONCE, 0, 0, 0, 1, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd0, sttab_pkg::KIND_ONCE, 0, 0, 0, 1, '0),
         make_row(sttab_pkg::CMD_TICK, 4'd0, sttab_pkg::KIND_ONCE, 0, 0, 0, 1, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd0, sttab_pkg::KIND_ONCE, 32'd0, 32'd0, 1, 1,
                  8'b0_0000_0_0_1),
         make_row(sttab_pkg::CMD_TICK, 4'd0, sttab_pkg::KIND_ONCE, 0, 0, 0, 1,
                  8'b0_0000_0_1_1),
         make_row(sttab_pkg::CMD_SERVICE, 4'd0, sttab_pkg::KIND_ONCE, 0, 0, 0, 1,
                  8'b1_0000_0_1_0),
         make_row(sttab_pkg::CMD_SETUP, 4'd15, sttab_pkg::KIND_CYCLIC, 32'd1, 32'd2, 1, 1,
                  8'b0_0000_0_0_1),
         make_row(sttab_pkg::CMD_TICK, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 1,
                  8'b0_0000_0_1_1),
         make_row(sttab_pkg::CMD_SERVICE, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 1,
                  8'b1_1111_0_0_1),
         make_row(sttab_pkg::CMD_TICK, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_TICK, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd3, KIND_DELAY, 32'd1, 32'd0, 1, 0, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd7, KIND_SPARE, 32'd2, 32'hffff_ffff, 1, 0, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd9, sttab_pkg::KIND_CYCLIC, 32'hffff_ffff,
                  32'hffff_ffff, 0, 0, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd3, sttab_pkg::KIND_ONCE, 32'd2, 32'd5, 0, 0, '0),
         make_row(sttab_pkg::CMD_SETUP, 4'd15, sttab_pkg::KIND_CYCLIC, 32'd1, 32'd0, 1, 0,
                  '0),
         make_row(sttab_pkg::CMD_TICK, 4'd7, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_TICK, 4'd3, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd7, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_SERVICE, 4'd3, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_RELEASE, 4'd9, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0),
         make_row(sttab_pkg::CMD_RELEASE, 4'd15, sttab_pkg::KIND_ONCE, 0, 0, 0, 0, '0)
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send(directed[i]);

      // random command stream with idle bursts, quiet at the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if (!quiet && $urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
         if (n == RANDOM_ITEMS / 2) begin
            pause(1);
            while (pending_status.size() != 0) @(negedge clock);
         end
         send(random_row());
      end

      @(negedge clock);
      start = 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
